// ===== src/rgba_pkg.sv =====
// Package with the pixel beat types, pipeline stage type and arithmetic constants of the blender.
package rgba_pkg;

   localparam int CHAN_COUNT  = 3;
   localparam int PIX_W       = 8;
   localparam int PROD_W      = 16;
   localparam int NUM_W       = 24;
   localparam int REM_W       = 25;
   localparam int DEN_W       = 17;
   localparam int DIV_STEPS   = 8;
   localparam int ALPHA_MUL_W = 33;
   localparam int ALPHA_SHIFT = 23;

   localparam logic [PIX_W-1:0]       CH_MAX     = 8'd255;
   localparam logic [DEN_W-1:0]       ROUND_HALF = 17'd127;
   localparam logic [ALPHA_MUL_W-1:0] ALPHA_MUL  = 33'd32897;

   typedef struct packed {
      logic [7:0] fg_red;
      logic [7:0] fg_green;
      logic [7:0] fg_blue;
      logic [7:0] fg_opacity;
      logic [7:0] bg_red;
      logic [7:0] bg_green;
      logic [7:0] bg_blue;
      logic [7:0] bg_opacity;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } pixel_out_type;

   typedef struct packed {
      logic                                valid;
      logic                                zero;
      logic [DEN_W-1:0]                    den;
      logic [CHAN_COUNT-1:0][REM_W-1:0]    rem;
      logic [CHAN_COUNT-1:0][PIX_W-1:0]    quo;
      logic [PIX_W-1:0]                    alpha;
   } div_stage_type;

endpackage

// ===== src/rgba_prep.sv =====
// Front stages of the blender: products, numerators, denominator and output alpha.
module rgba_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  rgba_pkg::pixel_in_type in_pix,
   output rgba_pkg::div_stage_type out_st
);
   import rgba_pkg::*;

   logic [CHAN_COUNT-1:0][PIX_W-1:0] fc;
   logic [CHAN_COUNT-1:0][PIX_W-1:0] bc;

   logic                              s1_valid_ff;
   logic [PIX_W-1:0]                  s1_a_ff;
   logic [PIX_W-1:0]                  s1_b_ff;
   logic [PROD_W-1:0]                 s1_ab_ff;
   logic [CHAN_COUNT-1:0][PROD_W-1:0] s1_pa_ff, s1_pa_in;
   logic [CHAN_COUNT-1:0][PROD_W-1:0] s1_pb_ff, s1_pb_in;

   logic                              s2_valid_ff;
   logic [DEN_W-1:0]                  s2_d_ff, s2_d_in;
   logic [CHAN_COUNT-1:0][NUM_W-1:0]  s2_n_ff, s2_n_in;

   div_stage_type                     s3_ff, s3_in;
   logic [ALPHA_MUL_W-1:0]            alpha_prod;

   assign fc = {in_pix.fg_blue, in_pix.fg_green, in_pix.fg_red};
   assign bc = {in_pix.bg_blue, in_pix.bg_green, in_pix.bg_red};

   always_comb begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
         s1_pa_in[c] = PROD_W'(fc[c]) * PROD_W'(in_pix.fg_opacity);
         s1_pb_in[c] = PROD_W'(bc[c]) * PROD_W'(in_pix.bg_opacity);
      end
   end

   always_comb begin
      s2_d_in = DEN_W'(DEN_W'(CH_MAX) * (DEN_W'(s1_a_ff) + DEN_W'(s1_b_ff)))
                - DEN_W'(s1_ab_ff);
      for (int c = 0; c < CHAN_COUNT; c++) begin
         s2_n_in[c] = ({s1_pa_ff[c], 8'b0} - NUM_W'(s1_pa_ff[c]))
                      + NUM_W'(NUM_W'(s1_pb_ff[c]) * NUM_W'(CH_MAX - s1_a_ff));
      end
   end

   always_comb begin
      alpha_prod   = ALPHA_MUL_W'(s2_d_ff + ROUND_HALF) * ALPHA_MUL;
      s3_in.valid  = s2_valid_ff;
      s3_in.zero   = (s2_d_ff == '0);
      s3_in.den    = DEN_W'({s2_d_ff[DEN_W-2:0], 1'b0});
      s3_in.quo    = '0;
      s3_in.alpha  = alpha_prod[ALPHA_SHIFT +: PIX_W];
      for (int c = 0; c < CHAN_COUNT; c++) begin
         s3_in.rem[c] = REM_W'({s2_n_ff[c], 1'b0}) + REM_W'(s2_d_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff    <= in_pix.fg_opacity;
         s1_b_ff    <= in_pix.bg_opacity;
         s1_ab_ff   <= PROD_W'(in_pix.fg_opacity) * PROD_W'(in_pix.bg_opacity);
         s1_pa_ff   <= s1_pa_in;
         s1_pb_ff   <= s1_pb_in;
         s2_d_ff    <= s2_d_in;
         s2_n_ff    <= s2_n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_ff <= s3_in;
      end
   end

   assign out_st = s3_ff;

endmodule

// ===== src/rgba_div_step.sv =====
// One registered restoring division step that yields one quotient bit for each colour channel.
module rgba_div_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  rgba_pkg::div_stage_type in_st,
   output rgba_pkg::div_stage_type out_st
);
   import rgba_pkg::*;

   div_stage_type      st_ff, st_in;
   logic [REM_W:0]     diff [CHAN_COUNT];
   logic [REM_W-1:0]   kept [CHAN_COUNT];
   logic [REM_W-2:0]   den_sh;

   always_comb begin
      st_in  = in_st;
      den_sh = {in_st.den, 7'b0};
      for (int c = 0; c < CHAN_COUNT; c++) begin
         diff[c] = {1'b0, in_st.rem[c]} - {2'b0, den_sh};
         kept[c] = diff[c][REM_W] ? in_st.rem[c] : diff[c][REM_W-1:0];
         st_in.rem[c] = {kept[c][REM_W-2:0], 1'b0};
         st_in.quo[c] = {in_st.quo[c][PIX_W-2:0], ~diff[c][REM_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_st = st_ff;

endmodule

// ===== src/rgba_over_alpha_blend.sv =====
// Top level of the Porter-Duff over blender for non-premultiplied RGBA8 pixels.
// Each beat on the req_ channel carries a foreground and a background pixel; each
// beat on the rsp_ channel carries the composited pixel, one result per request,
// in request order.
// Both channels use valid and stall: a beat moves at a rising clock edge where
// valid is high and stall is low.
// The pipeline is eleven register stages deep: three stages form the products,
// the numerators, the denominator and the output alpha, and eight stages of a
// restoring divider produce one quotient bit each for the three colours.
// A new request can be taken in every cycle in which req_stall is low, so
// throughput is one pixel per clock while the receiver does not stall.
// The whole pipeline advances together. When the receiver stalls while a response
// is held, every stage holds its contents and req_stall is raised; stages behind
// empty bubbles are not squeezed out, so nothing is lost or repeated.
// A synchronous reset clears all valid bits; the data registers are not reset.
module rgba_over_alpha_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rgba_pkg::pixel_in_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rgba_pkg::pixel_out_type rsp_data
);
   import rgba_pkg::*;

   logic          adv;
   div_stage_type chain [DIV_STEPS+1];
   div_stage_type last;

   assign adv       = ~(chain[DIV_STEPS].valid & rsp_stall);
   assign req_stall = ~adv;

   rgba_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_pix   (req_data),
      .out_st   (chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      rgba_div_step u_step (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .in_st  (chain[i]),
         .out_st (chain[i+1])
      );
   end

   assign last               = chain[DIV_STEPS];
   assign rsp_valid          = last.valid;
   assign rsp_data.out_red   = last.zero ? '0 : last.quo[0];
   assign rsp_data.out_green = last.zero ? '0 : last.quo[1];
   assign rsp_data.out_blue  = last.zero ? '0 : last.quo[2];
   assign rsp_data.out_alpha = last.alpha;

endmodule
